@@ src/byte_stream_loaded_mailbox_top_defines.svh @@
// ----------------------------------------------------------------------------
// Byte stream loaded mailbox assertion macros
// Shared property forms for the mailbox top level checks.
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_LOADED_MAILBOX_TOP_DEFINES_SVH
`define BYTE_STREAM_LOADED_MAILBOX_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSLM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSLM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/bslm_pkg.sv @@
// ----------------------------------------------------------------------------
// Byte stream loaded mailbox package
// Sizes, command codes, controller types and byte helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bslm_pkg;

	localparam int BUFFER_BYTES = 4096;
	localparam int MBX_WORDS    = BUFFER_BYTES / 4;
	localparam int WORD_AW      = $clog2(MBX_WORDS);
	localparam int POS_W        = $clog2(BUFFER_BYTES);

	localparam logic [2:0] CMD_RD   = 3'd0;
	localparam logic [2:0] CMD_WR   = 3'd1;
	localparam logic [2:0] CMD_HOST = 3'd2;
	localparam logic [2:0] CMD_LVL  = 3'd3;
	localparam logic [2:0] CMD_TX   = 3'd4;

	localparam logic [7:0] OP_EVENT = 8'd0;
	localparam logic [7:0] OP_LOAD  = 8'd1;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic accept;
		logic commit;
	} ctl_t;

	typedef struct packed {
		logic clr_last;
		logic out_ready;
	} sts_t;

	function automatic logic [WORD_AW-1:0] word_index(input logic [11:0] addr);
		logic [31:0] w;
		w = 32'(addr) >> 2;
		return w[WORD_AW-1:0];
	endfunction

	function automatic logic [31:0] put_byte(input logic [31:0] word,
		input logic [1:0] lane, input logic [7:0] b);
		logic [31:0] r;
		r = word;
		for (int i = 0; i < 4; i++) begin
			if (2'(i) == lane) begin
				r[8*i +: 8] = b;
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] get_byte(input logic [31:0] word,
		input logic [1:0] lane);
		return word[{lane, 3'b000} +: 8];
	endfunction

endpackage

`default_nettype wire

@@ src/bslm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bslm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ src/bslm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Mailbox controller
// Sequences the clearing pass, item acceptance and result commit.
// ----------------------------------------------------------------------------
`default_nettype none

module bslm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire bslm_pkg::sts_t sts,
	output bslm_pkg::ctl_t     ctl
);

	bslm_pkg::state_t state_q;
	bslm_pkg::state_t state_d;

	always_comb begin
		state_d      = state_q;
		ctl.clr_step = 1'b0;
		ctl.accept   = 1'b0;
		ctl.commit   = 1'b0;
		case (state_q)
			bslm_pkg::ST_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = bslm_pkg::ST_IDLE;
				end
			end
			bslm_pkg::ST_IDLE: begin
				if (in_valid) begin
					ctl.accept = 1'b1;
					state_d    = bslm_pkg::ST_EXEC;
				end
			end
			bslm_pkg::ST_EXEC: begin
				if (sts.out_ready) begin
					ctl.commit = 1'b1;
					state_d    = bslm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bslm_pkg::ST_CLEAR;
			end
		endcase
	end

	assign in_stall = (state_q != bslm_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bslm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ src/bslm_dpath.sv @@
// ----------------------------------------------------------------------------
// Mailbox datapath
// Memory, load and dump position state, request registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bslm_dpath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bslm_pkg::ctl_t ctl,
	output bslm_pkg::sts_t      sts,
	input  wire logic [2:0]     cmd,
	input  wire logic [11:0]    bus_addr,
	input  wire logic [31:0]    write_data,
	input  wire logic [7:0]     host_byte,
	input  wire logic           level,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [31:0]         read_data,
	output logic                event_irq,
	output logic                response_irq,
	output logic                tx_valid,
	output logic [7:0]          tx_byte,
	output logic                tx_last
);

	localparam logic [bslm_pkg::POS_W-1:0] POS_LAST =
		bslm_pkg::POS_W'(bslm_pkg::BUFFER_BYTES - 1);
	localparam logic [bslm_pkg::WORD_AW-1:0] CLR_LAST =
		bslm_pkg::WORD_AW'(bslm_pkg::MBX_WORDS - 1);

	logic [bslm_pkg::WORD_AW-1:0] clr_cnt_q;
	logic                         load_active_q;
	logic [bslm_pkg::POS_W-1:0]   load_pos_q;
	logic                         dump_active_q;
	logic [bslm_pkg::POS_W-1:0]   dump_pos_q;
	logic                         last_level_q;

	logic [2:0]                   cmd_q;
	logic [bslm_pkg::WORD_AW-1:0] widx_q;
	logic [1:0]                   lane_q;
	logic [31:0]                  wdata_q;
	logic [7:0]                   hbyte_q;
	logic                         level_q;

	logic                         out_valid_q;
	logic [31:0]                  read_data_q;
	logic                         event_irq_q;
	logic                         response_irq_q;
	logic                         tx_valid_q;
	logic [7:0]                   tx_byte_q;
	logic                         tx_last_q;

	logic [bslm_pkg::POS_W-1:0]   rpos;
	logic [bslm_pkg::WORD_AW-1:0] raddr;
	logic [31:0]                  rdata;
	logic                         we;
	logic [bslm_pkg::WORD_AW-1:0] waddr;
	logic [31:0]                  wdata;
	logic                         host_store;

	always_comb begin
		case (cmd)
			bslm_pkg::CMD_HOST: rpos = load_pos_q;
			bslm_pkg::CMD_TX:   rpos = dump_pos_q;
			default:            rpos = '0;
		endcase
		if (cmd inside {bslm_pkg::CMD_HOST, bslm_pkg::CMD_TX}) begin
			raddr = rpos[bslm_pkg::POS_W-1:2];
		end else begin
			raddr = bslm_pkg::word_index(bus_addr);
		end
	end

	assign host_store = (cmd_q == bslm_pkg::CMD_HOST) && load_active_q;

	always_comb begin
		we    = ctl.clr_step || (ctl.commit && (cmd_q == bslm_pkg::CMD_WR || host_store));
		waddr = ctl.clr_step ? clr_cnt_q : widx_q;
		if (ctl.clr_step) begin
			wdata = '0;
		end else if (cmd_q == bslm_pkg::CMD_WR) begin
			wdata = wdata_q;
		end else begin
			wdata = bslm_pkg::put_byte(rdata, lane_q, hbyte_q);
		end
	end

	bslm_ram #(
		.WIDTH(32),
		.DEPTH(bslm_pkg::MBX_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ctl.accept),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q   <= cmd;
			widx_q  <= raddr;
			lane_q  <= rpos[1:0];
			wdata_q <= write_data;
			hbyte_q <= host_byte;
			level_q <= level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q     <= '0;
			load_active_q <= 1'b0;
			load_pos_q    <= '0;
			dump_active_q <= 1'b0;
			dump_pos_q    <= '0;
			last_level_q  <= 1'b0;
		end else begin
			if (ctl.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (ctl.commit) begin
				case (cmd_q)
					bslm_pkg::CMD_HOST: begin
						if (!load_active_q) begin
							if (hbyte_q == bslm_pkg::OP_LOAD) begin
								load_active_q <= 1'b1;
								load_pos_q    <= '0;
							end
						end else if (load_pos_q == POS_LAST) begin
							load_active_q <= 1'b0;
							load_pos_q    <= '0;
						end else begin
							load_pos_q <= load_pos_q + 1'b1;
						end
					end
					bslm_pkg::CMD_LVL: begin
						if (level_q && !last_level_q) begin
							dump_active_q <= 1'b1;
							dump_pos_q    <= '0;
						end
						last_level_q <= level_q;
					end
					bslm_pkg::CMD_TX: begin
						if (dump_active_q) begin
							if (dump_pos_q == POS_LAST) begin
								dump_active_q <= 1'b0;
								dump_pos_q    <= '0;
							end else begin
								dump_pos_q <= dump_pos_q + 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			read_data_q    <= (cmd_q == bslm_pkg::CMD_RD) ? rdata : '0;
			event_irq_q    <= (cmd_q == bslm_pkg::CMD_HOST) && !load_active_q
				&& (hbyte_q == bslm_pkg::OP_EVENT);
			response_irq_q <= host_store && (load_pos_q == POS_LAST);
			tx_valid_q     <= (cmd_q == bslm_pkg::CMD_TX) && dump_active_q;
			tx_byte_q      <= ((cmd_q == bslm_pkg::CMD_TX) && dump_active_q)
				? bslm_pkg::get_byte(rdata, lane_q) : '0;
			tx_last_q      <= (cmd_q == bslm_pkg::CMD_TX) && dump_active_q
				&& (dump_pos_q == POS_LAST);
		end
	end

	assign sts.clr_last  = (clr_cnt_q == CLR_LAST);
	assign sts.out_ready = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign read_data    = read_data_q;
	assign event_irq    = event_irq_q;
	assign response_irq = response_irq_q;
	assign tx_valid     = tx_valid_q;
	assign tx_byte      = tx_byte_q;
	assign tx_last      = tx_last_q;

endmodule

`default_nettype wire

@@ src/byte_stream_loaded_mailbox_top.sv @@
// ----------------------------------------------------------------------------
// Byte stream loaded mailbox top level
// Mailbox memory shared by a word bus port and a host byte stream.
// ----------------------------------------------------------------------------
// Each input request carries one command: a bus word read or write, a host
// stream byte, a message-ready level sample or a transmit slot. Every request
// yields exactly one result with read data, interrupt pulses and a dump byte.
// After reset the block clears its memory, one word per cycle, all
// BUFFER_BYTES / 4 words (1024 words here), and holds in_stall high.
// A request is read from the memory in the cycle it is accepted and is
// committed, with any byte or word write, once the result register is free;
// the commit loads its result into the result register. The single memory
// read and write path lets a new request in only after the last has committed.
// The result register lets the next request be accepted while a result waits.
// When the receiver stalls, the result holds and at most one more request is
// taken, which then waits to commit until the result register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_stream_loaded_mailbox_top_defines.svh"

module byte_stream_loaded_mailbox_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  cmd,
	input  wire logic [11:0] bus_addr,
	input  wire logic [31:0] write_data,
	input  wire logic [7:0]  host_byte,
	input  wire logic        level,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      read_data,
	output logic             event_irq,
	output logic             response_irq,
	output logic             tx_valid,
	output logic [7:0]       tx_byte,
	output logic             tx_last
);

	bslm_pkg::ctl_t ctl;
	bslm_pkg::sts_t sts;

	bslm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	bslm_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cmd          (cmd),
		.bus_addr     (bus_addr),
		.write_data   (write_data),
		.host_byte    (host_byte),
		.level        (level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.event_irq    (event_irq),
		.response_irq (response_irq),
		.tx_valid     (tx_valid),
		.tx_byte      (tx_byte),
		.tx_last      (tx_last)
	);

	`BSLM_ASSERT_NEXT(a_accept_then_busy, in_valid && !in_stall, in_stall, "Request taken.")
	`BSLM_ASSERT_SAME(a_clear_stalls, ctl.clr_step, in_stall, "Request open during clearing.")
	`BSLM_ASSERT_NEXT(a_commit_valid, ctl.commit, out_valid, "Committed result not presented.")
	`BSLM_ASSERT_SAME(a_last_has_byte, out_valid && tx_last, tx_valid, "Last flag without a byte.")

endmodule

`default_nettype wire
